// ===== src/xtea_pkg.sv =====
// xtea_pkg: shared constants, types and helper functions for the xtea block cipher
// used by xtea_round, xtea_out_skid and xtea_block_cipher; no dependencies
package xtea_pkg;

    localparam int ROUNDS    = 32;
    localparam int STAGES    = 2 * ROUNDS;
    localparam int KEY_WORDS = 4;
    localparam int KIDX_W    = $clog2(KEY_WORDS);
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic  op;
        t_word x;
        t_word y;
    } t_blk;

    // per-stage constants: round sum and key word for each direction
    typedef struct packed {
        t_word              enc_sum;
        t_word              dec_sum;
        logic [KIDX_W-1:0]  enc_kidx;
        logic [KIDX_W-1:0]  dec_kidx;
        logic               enc_upd_x;
    } t_stage_const;

    function automatic t_word mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // one half-round per stage; encryption updates x on even stages,
    // decryption runs the rounds backwards and updates y on even stages
    function automatic t_stage_const stage_const(input int k);
        t_stage_const c;
        int           r;
        t_word        es;
        t_word        ds;
        r = k >> 1;
        if ((k & 1) == 0) begin
            es = WORD_W'(r) * DELTA;
            ds = WORD_W'(ROUNDS - r) * DELTA;
            c.enc_kidx = es[KIDX_W-1:0];
            c.dec_kidx = ds[11 +: KIDX_W];
            c.enc_upd_x = 1'b1;
        end else begin
            es = WORD_W'(r + 1) * DELTA;
            ds = WORD_W'(ROUNDS - r - 1) * DELTA;
            c.enc_kidx = es[11 +: KIDX_W];
            c.dec_kidx = ds[KIDX_W-1:0];
            c.enc_upd_x = 1'b0;
        end
        c.enc_sum = es;
        c.dec_sum = ds;
        return c;
    endfunction

endpackage

// ===== src/xtea_round.sv =====
// xtea_round: one registered feistel half-round of the xtea pipeline
// depends on xtea_pkg for block types, stage constants and the mix function
module xtea_round
    import xtea_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_blk         i_blk,
    input  t_key         i_key,
    input  t_stage_const i_const,
    output logic         o_valid,
    output t_blk         o_blk
);

    logic              upd_x;
    t_word             src;
    t_word             dst;
    t_word             sum;
    logic [KIDX_W-1:0] kidx;
    t_word             f;
    t_word             res;

    logic r_valid;
    t_blk r_blk;
    logic n_valid;
    t_blk n_blk;

    always_comb begin
        upd_x = i_const.enc_upd_x ^ (i_blk.op == OP_DECRYPT);
        src   = upd_x ? i_blk.y : i_blk.x;
        dst   = upd_x ? i_blk.x : i_blk.y;
        sum   = (i_blk.op == OP_DECRYPT) ? i_const.dec_sum : i_const.enc_sum;
        kidx  = (i_blk.op == OP_DECRYPT) ? i_const.dec_kidx : i_const.enc_kidx;
        f     = mix(src) ^ (sum + i_key[kidx]);
        res   = (i_blk.op == OP_DECRYPT) ? (dst - f) : (dst + f);

        n_valid  = i_valid;
        n_blk.op = i_blk.op;
        n_blk.x  = upd_x ? res : i_blk.x;
        n_blk.y  = upd_x ? i_blk.y : res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

// ===== src/xtea_out_skid.sv =====
// xtea_out_skid: output register plus one skid entry behind the round pipeline
// depends on xtea_pkg for the block type; freezes the pipeline while the skid is full
module xtea_out_skid
    import xtea_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_blk  i_blk,
    output logic  o_pipe_en,
    output logic  o_valid,
    output t_word o_first_out,
    output t_word o_second_out,
    input  logic  i_stall
);

    logic r_out_valid;
    t_blk r_out;
    logic r_skid_valid;
    t_blk r_skid;

    logic out_free;
    logic depart;

    assign out_free = !r_out_valid || !i_stall;
    assign depart   = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || depart;
                r_skid_valid <= 1'b0;
            end else if (depart) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= i_blk;
            end
        end else if (depart) begin
            r_skid <= i_blk;
        end
    end

    assign o_pipe_en    = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_first_out  = r_out.x;
    assign o_second_out = r_out.y;

    // skid only fills behind a blocked output
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a transaction while output is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled without a blocked output");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> r_skid_valid)
        else $error("skid transaction dropped while output stalled");

endmodule

// ===== src/xtea_block_cipher.sv =====
// xtea_block_cipher: 32-round xtea encrypt/decrypt, one feistel half-round per stage
// an input transaction passes the 64 round stages and then the output register before it
// appears as an output transaction
// throughput: one block per cycle while o_stall is low; 64 round stages set the latency
// output stall freezes the pipeline once the skid entry has caught the extra block
// reset (synchronous, active low) clears key words to zero and all valid bits
module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [KIDX_W-1:0] i_cfg_index,
    input  t_word             i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  t_word             i_first_word,
    input  t_word             i_second_word,
    output logic              o_valid,
    input  logic              i_stall,
    output t_word             o_first_out,
    output t_word             o_second_out
);

    t_key r_key;

    logic pipe_en;
    logic vld [0:STAGES];
    t_blk blk [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign vld[0]    = i_valid;
    assign blk[0].op = i_opcode;
    assign blk[0].x  = i_first_word;
    assign blk[0].y  = i_second_word;

    for (genvar g = 0; g < STAGES; g++) begin : g_round
        localparam t_stage_const SC = stage_const(g);
        xtea_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (vld[g]),
            .i_blk   (blk[g]),
            .i_key   (r_key),
            .i_const (SC),
            .o_valid (vld[g+1]),
            .o_blk   (blk[g+1])
        );
    end

    xtea_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (vld[STAGES]),
        .i_blk        (blk[STAGES]),
        .o_pipe_en    (pipe_en),
        .o_valid      (o_valid),
        .o_first_out  (o_first_out),
        .o_second_out (o_second_out),
        .i_stall      (i_stall)
    );

    assign o_stall = !pipe_en;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for xtea_block_cipher (32-round xtea encrypt/decrypt)
// depends on src/xtea_pkg.sv and src/xtea_block_cipher.sv; keys set through the config port
// blocks are checked against an in-bench round model under the key currently in force
module tb_top
    import xtea_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PERCENT   = 9;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BLOCKS   = 135;

    typedef struct packed {
        logic  op;
        t_word first;
        t_word second;
    } t_block_req;

    typedef struct packed {
        t_word first;
        t_word second;
    } t_block_res;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [KIDX_W-1:0] i_cfg_index   = '0;
    t_word             i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic              i_opcode      = OP_ENCRYPT;
    t_word             i_first_word  = '0;
    t_word             i_second_word = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    t_word             o_first_out;
    t_word             o_second_out;

    t_block_req pending_blocks[$];
    t_block_res expected_blocks[$];

    t_key key_in_force = '0;  // key as the block sees it, tracked from config writes
    t_key plan_key     = '0;  // key the stimulus generator assumes for round trips

    int unsigned blocks_offered = 0;
    int unsigned blocks_in      = 0;
    int unsigned results_seen   = 0;
    int unsigned encrypt_count  = 0;
    int unsigned decrypt_count  = 0;
    int unsigned key_settings   = 1;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    bit          idle_on        = 1'b1;

    xtea_block_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_first_out   (o_first_out),
        .o_second_out  (o_second_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_word feistel_mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function automatic t_block_res xtea_transform(input t_block_req blk, input t_key key);
        t_word      a;
        t_word      b;
        t_word      s;
        t_block_res res;
        a = blk.first;
        b = blk.second;
        if (blk.op == OP_ENCRYPT) begin
            s = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                a = a + (feistel_mix(b) ^ (s + key[s[1:0]]));
                s = s + DELTA;
                b = b + (feistel_mix(a) ^ (s + key[s[12:11]]));
            end
        end else begin
            s = DELTA * t_word'(ROUNDS);
            for (int r = 0; r < ROUNDS; r++) begin
                b = b - (feistel_mix(a) ^ (s + key[s[12:11]]));
                s = s - DELTA;
                a = a - (feistel_mix(b) ^ (s + key[s[1:0]]));
            end
        end
        res.first  = a;
        res.second = b;
        return res;
    endfunction

    // mostly uniform words, with corner values mixed in
    function automatic t_word pick_word();
        t_word w;
        w = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(5))
                0: w = 32'h0000_0000;
                1: w = 32'hffff_ffff;
                2: w = 32'h8000_0000;
                3: w = 32'h7fff_ffff;
                4: w = 32'h0000_0001;
                default: w = 32'hffff_fffe;
            endcase
        end
        return w;
    endfunction

    task automatic push_block(input logic op, input t_word first, input t_word second);
        t_block_req blk;
        blk.op     = op;
        blk.first  = first;
        blk.second = second;
        pending_blocks.push_back(blk);
    endtask

    // both directions on the same block
    task automatic push_both(input t_word first, input t_word second);
        push_block(OP_ENCRYPT, first, second);
        push_block(OP_DECRYPT, first, second);
    endtask

    // encrypt a block, then decrypt the expected ciphertext back
    task automatic push_round_trip(input t_word first, input t_word second);
        t_block_req blk;
        t_block_res ct;
        blk.op     = OP_ENCRYPT;
        blk.first  = first;
        blk.second = second;
        ct = xtea_transform(blk, plan_key);
        push_block(OP_ENCRYPT, first, second);
        push_block(OP_DECRYPT, ct.first, ct.second);
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || i_valid || expected_blocks.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_key(input t_word k0, input t_word k1, input t_word k2, input t_word k3);
        t_key nk;
        nk = {k3, k2, k1, k0};
        wait_drained();
        for (int k = 0; k < KEY_WORDS; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= KIDX_W'(k);
            i_cfg_data  <= nk[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        plan_key = nk;
        key_settings++;
    endtask

    task automatic random_blocks(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 25) begin
                push_round_trip(pick_word(), pick_word());
                n += 2;
            end else begin
                push_block(logic'($urandom_range(1)), pick_word(), pick_word());
                n++;
            end
        end
    endtask

    // sender: one transaction held until taken, random gaps between items
    always @(negedge i_clk) begin : sender_p
        t_block_req blk;
        if (i_rst_n && blocks_in == blocks_offered) begin
            if (pending_blocks.size() != 0 &&
                !(idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
                blk = pending_blocks.pop_front();
                i_opcode      <= blk.op;
                i_first_word  <= blk.first;
                i_second_word <= blk.second;
                i_valid       <= 1'b1;
                blocks_offered++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge i_clk) begin : receiver_p
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : monitor_p
        bit         busy;
        t_block_req blk;
        t_block_res want;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                key_in_force[i_cfg_index] = i_cfg_data;
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                results_seen++;
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result %08h %08h", $time,
                             o_first_out, o_second_out);
                    error_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (o_first_out !== want.first) begin
                        $display("%0t: first_out mismatch: expected %08h, got %08h",
                                 $time, want.first, o_first_out);
                        error_count++;
                    end
                    if (o_second_out !== want.second) begin
                        $display("%0t: second_out mismatch: expected %08h, got %08h",
                                 $time, want.second, o_second_out);
                        error_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                busy = 1'b1;
                blk.op     = i_opcode;
                blk.first  = i_first_word;
                blk.second = i_second_word;
                expected_blocks.push_back(xtea_transform(blk, key_in_force));
                if (blk.op == OP_ENCRYPT)
                    encrypt_count++;
                else
                    decrypt_count++;
                blocks_in++;
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : stimulus_p
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero key out of reset, corner blocks both ways
        push_both(32'h0000_0000, 32'h0000_0000);
        push_both(32'hffff_ffff, 32'hffff_ffff);
        push_both(32'h0000_0000, 32'hffff_ffff);
        push_both(32'hffff_ffff, 32'h0000_0000);
        push_both(32'h8000_0000, 32'h0000_0001);
        push_both(32'h7fff_ffff, 32'hffff_fffe);
        push_both(32'haaaa_aaaa, 32'h5555_5555);
        push_round_trip(32'h0123_4567, 32'h89ab_cdef);

        set_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_both(32'h0000_0000, 32'h0000_0000);
        push_round_trip(32'hffff_ffff, 32'h0000_0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f);
                1: set_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
                2: set_key(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_fffe);
                default: set_key($urandom, $urandom, $urandom, $urandom);
            endcase
            idle_on = (p != 3);
            if (p == 5)
                hold_asks++;
            random_blocks(PHASE_BLOCKS);
        end

        wait_drained();
        idle_on = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d encrypt and %0d decrypt blocks under %0d keys, %0d results",
                 encrypt_count, decrypt_count, key_settings, results_seen);
        $display("included a %0d-cycle output hold-off and drained pauses at each key change",
                 LONG_HOLD);
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d errors, %0d results still expected", error_count,
                     expected_blocks.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/xtea_pkg.sv
src/xtea_round.sv
src/xtea_out_skid.sv
src/xtea_block_cipher.sv
dv/tb_top.sv
